// ===== design/scdb_pkg.sv =====
// Shared types, codes and constants of the SATA command descriptor builder.
// No dependencies; every other design file refers to this package by scoped names.
package scdb_pkg;

    // Fixed field widths
    localparam int SLOT_W  = 5;
    localparam int CFG_W   = 6;
    localparam int KIND_W  = 3;
    localparam int NREG_W  = 6;    // wide enough for any region count up to 63
    localparam int LEN_W   = 32;

    // Build constants
    localparam int SLOTS_DEF      = 32;
    localparam int MAX_REGIONS    = 8;
    localparam int REGION_BYTES   = 4194304;          // 0x400000, a power of two
    localparam int REGION_SHIFT   = $clog2(REGION_BYTES);
    localparam int RB_W           = REGION_SHIFT + 1; // holds REGION_BYTES itself
    localparam int COUNT_CODE_W   = 22;               // 0x3FFFFF mask
    localparam logic [CFG_W-1:0] SLOT_COUNT_RESET = 6'd32;

    // FIS and header constants
    localparam logic [7:0] FIS_TYPE_H2D = 8'h27;
    localparam logic [7:0] FIS_CMD_BIT  = 8'h80;
    localparam logic [7:0] DEV_BASE     = 8'hA0;
    localparam logic [7:0] DEV_LBA_BIT  = 8'h40;
    localparam logic [7:0] FIS_CONTROL  = 8'h08;
    localparam logic [4:0] FIS_DWORDS   = 5'd5;

    // Input action codes
    localparam logic ACT_SUBMIT  = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_HEADER   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REGION   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NO_SLOT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TOO_LONG = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd4;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;   // power of two, so the pointers wrap by themselves
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] slot_to_free;
        logic [7:0]        ata_command;
        logic [47:0]       lba;
        logic              lba28_mode;
        logic [15:0]       sector_count;
        logic [15:0]       features;
        logic              is_write;
        logic [63:0]       buffer_address;
        logic [LEN_W-1:0]  transfer_length;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [SLOT_W-1:0]       slot;
        logic [31:0]             header_dword;
        logic [63:0]             fis_low;
        logic [63:0]             fis_upper;
        logic [63:0]             region_address;
        logic [COUNT_CODE_W-1:0] region_count_code;
        logic                    last;
    } out_item_t;

    // A classified item waiting for the back end
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [NREG_W-1:0] nreg;
        logic [31:0]       header_dword;
        logic [63:0]       fis_low;
        logic [63:0]       fis_upper;
        logic [63:0]       base;
        logic [LEN_W-1:0]  len;
    } job_t;

endpackage

// ===== design/sata_command_descriptor_builder.sv =====
// Top level of the SATA command descriptor builder: front end, queue and back end.
// Depends on scdb_pkg, scdb_front, scdb_queue and scdb_back.
// An accepted item is queued in a register, then its first result in the output register.
// A release or rejected submit gives one result, a submit a header and one per region
// (at most 9 in all); the back end emits one per unstalled cycle from the queue head.
// Input items are taken every cycle while the two-entry queue has room.
// Reset (rst_n low, asynchronous) frees every slot, sets the slot count to 32 and empties
// the queue and output register; no clearing pass follows.
module sata_command_descriptor_builder #(
    parameter int SLOTS = scdb_pkg::SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  scdb_pkg::in_item_t          in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output scdb_pkg::out_item_t         out_item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [scdb_pkg::CFG_W-1:0]  cfg_data
);

    // Classified items pass from the front end to the back end through the queue,
    // so a stalled output only holds up the front once the queue has filled.
    logic           push;
    scdb_pkg::job_t push_job;
    logic           queue_full;
    logic           pop;
    logic           head_valid;
    scdb_pkg::job_t head_job;

    // The front end owns the slot bitmap, so a submit directly after a release
    // sees the freed slot.
    scdb_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    scdb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // The back end walks a submit's header and region entries and pops the item
    // with its last result.
    scdb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

// ===== design/scdb_front.sv =====
// Front end: accepts items, holds the slot bitmap and slot count, classifies each item.
// Depends on scdb_pkg.
module scdb_front #(
    parameter int SLOTS = scdb_pkg::SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  scdb_pkg::in_item_t             in_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [scdb_pkg::CFG_W-1:0]     cfg_data,
    output logic                           push,
    output scdb_pkg::job_t                 push_job,
    input  logic                           queue_full
);

    localparam int NFULL_W = scdb_pkg::LEN_W + 1;

    logic [SLOTS-1:0]               busy_reg, busy_next;
    logic [scdb_pkg::CFG_W-1:0]     slot_count_reg;
    logic [SLOTS-1:0]               free_mask;
    logic [SLOTS-1:0]               lowest_free;
    logic                           found;
    logic [scdb_pkg::SLOT_W-1:0]    alloc_slot;
    logic [NFULL_W-1:0]             nreg_full;
    logic                           too_long;
    logic                           accept;
    logic [7:0]                     dev_byte;
    scdb_pkg::job_t                 job;

    assign accept    = in_valid && !queue_full;
    assign in_stall  = queue_full;
    assign cfg_ready = 1'b1;
    assign push      = accept;
    assign push_job  = job;

    // Lowest free slot below the usable count: isolate the lowest set bit, then encode.
    always_comb
    begin
        free_mask  = '0;
        alloc_slot = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            free_mask[i] = !busy_reg[i] && (scdb_pkg::CFG_W'(i) < slot_count_reg);
        end
        lowest_free = free_mask & (~free_mask + SLOTS'(1));
        for (int i = 0; i < SLOTS; i++)
        begin
            if (lowest_free[i])
            begin
                alloc_slot = alloc_slot | scdb_pkg::SLOT_W'(i);
            end
        end
        found = |free_mask;
    end

    assign nreg_full = (NFULL_W'(in_item.transfer_length) + NFULL_W'(scdb_pkg::REGION_BYTES - 1))
                       >> scdb_pkg::REGION_SHIFT;
    assign too_long  = nreg_full > NFULL_W'(scdb_pkg::MAX_REGIONS);

    assign dev_byte = scdb_pkg::DEV_BASE | scdb_pkg::DEV_LBA_BIT
                      | {4'h0, (in_item.lba28_mode ? in_item.lba[27:24] : 4'h0)};

    always_comb
    begin
        job       = '0;
        busy_next = busy_reg;
        priority if (in_item.action == scdb_pkg::ACT_RELEASE)
        begin
            job.kind = scdb_pkg::KIND_RELEASED;
            job.slot = in_item.slot_to_free;
            if (accept && (32'(in_item.slot_to_free) < SLOTS))
            begin
                busy_next = busy_reg & ~(SLOTS'(1) << in_item.slot_to_free);
            end
        end
        else if (too_long)
        begin
            job.kind = scdb_pkg::KIND_TOO_LONG;
        end
        else if (!found)
        begin
            job.kind = scdb_pkg::KIND_NO_SLOT;
        end
        else
        begin
            job.kind         = scdb_pkg::KIND_HEADER;
            job.slot         = alloc_slot;
            job.nreg         = scdb_pkg::NREG_W'(nreg_full);
            job.header_dword = {16'(nreg_full), 9'd0, in_item.is_write, 1'b0,
                                scdb_pkg::FIS_DWORDS};
            job.fis_low      = {dev_byte, in_item.lba[23:0], in_item.features[7:0],
                                in_item.ata_command, scdb_pkg::FIS_CMD_BIT,
                                scdb_pkg::FIS_TYPE_H2D};
            job.fis_upper    = {scdb_pkg::FIS_CONTROL, 8'h00, in_item.sector_count,
                                in_item.features[15:8], in_item.lba[47:24]};
            job.base         = in_item.buffer_address;
            job.len          = in_item.transfer_length;
            if (accept)
            begin
                busy_next = busy_reg | lowest_free;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= '0;
            slot_count_reg <= scdb_pkg::SLOT_COUNT_RESET;
        end
        else
        begin
            busy_reg <= busy_next;
            if (cfg_valid && cfg_ready)
            begin
                slot_count_reg <= cfg_data;
            end
        end
    end

    // An allocated slot was free when it was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_job.kind == scdb_pkg::KIND_HEADER)
            |-> (busy_reg & (SLOTS'(1) << push_job.slot)) == '0)
        else $error("front: allocated a slot that was already busy");

    // A rejected submit leaves the bitmap alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && (push_job.kind == scdb_pkg::KIND_NO_SLOT
                  || push_job.kind == scdb_pkg::KIND_TOO_LONG))
            |=> busy_reg == $past(busy_reg))
        else $error("front: rejected submit changed the slot bitmap");

endmodule

// ===== design/scdb_queue.sv =====
// Short queue of classified items between the front and back ends.
// Depends on scdb_pkg.
module scdb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  scdb_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output scdb_pkg::job_t head_job
);

    scdb_pkg::job_t                 entries_reg [scdb_pkg::QUEUE_DEPTH];
    logic [scdb_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [scdb_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [scdb_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign full       = count_reg == scdb_pkg::QCNT_W'(scdb_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + scdb_pkg::QCNT_W'(push) - scdb_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && !head_valid))
        else $error("queue: push while full or pop while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= scdb_pkg::QCNT_W'(scdb_pkg::QUEUE_DEPTH))
        else $error("queue: fill count beyond depth");

endmodule

// ===== design/scdb_back.sv =====
// Back end: expands queued items into results in an output register, one per unstalled cycle.
// Depends on scdb_pkg.
module scdb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  scdb_pkg::job_t      head_job,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output scdb_pkg::out_item_t out_item
);

    logic                           out_valid_reg, out_valid_next;
    scdb_pkg::out_item_t            out_item_reg, out_item_next;
    logic [scdb_pkg::NREG_W-1:0]    step_reg, step_next;
    logic [63:0]                    addr_reg, addr_next;
    logic [scdb_pkg::LEN_W-1:0]     rem_reg, rem_next;
    logic                           load;
    logic [scdb_pkg::RB_W-1:0]      chunk;
    logic [scdb_pkg::RB_W:0]        chunk_even;
    logic [scdb_pkg::COUNT_CODE_W-1:0] count_code;
    logic                           region_last;
    scdb_pkg::out_item_t            res;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign load      = !out_valid_reg || !out_stall;

    // Byte count of the current region, rounded up to even, minus one.
    always_comb
    begin
        if (rem_reg >= scdb_pkg::LEN_W'(scdb_pkg::REGION_BYTES))
        begin
            chunk = scdb_pkg::RB_W'(scdb_pkg::REGION_BYTES);
        end
        else
        begin
            chunk = rem_reg[scdb_pkg::RB_W-1:0];
        end
        chunk_even = ((scdb_pkg::RB_W+1)'(chunk) + (scdb_pkg::RB_W+1)'(1))
                     & ~(scdb_pkg::RB_W+1)'(1);
        count_code = scdb_pkg::COUNT_CODE_W'(chunk_even - (scdb_pkg::RB_W+1)'(1));
    end

    assign region_last = step_reg == head_job.nreg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        step_next      = step_reg;
        addr_next      = addr_reg;
        rem_next       = rem_reg;
        pop            = 1'b0;
        res            = '0;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                priority if (head_job.kind != scdb_pkg::KIND_HEADER)
                begin
                    res.kind = head_job.kind;
                    res.slot = head_job.slot;
                    res.last = 1'b1;
                    pop      = 1'b1;
                end
                else if (step_reg == '0)
                begin
                    res.kind         = scdb_pkg::KIND_HEADER;
                    res.slot         = head_job.slot;
                    res.header_dword = head_job.header_dword;
                    res.fis_low      = head_job.fis_low;
                    res.fis_upper    = head_job.fis_upper;
                    res.last         = head_job.nreg == '0;
                    addr_next        = head_job.base;
                    rem_next         = head_job.len;
                    if (head_job.nreg == '0)
                    begin
                        pop = 1'b1;
                    end
                    else
                    begin
                        step_next = scdb_pkg::NREG_W'(1);
                    end
                end
                else
                begin
                    res.kind              = scdb_pkg::KIND_REGION;
                    res.slot              = head_job.slot;
                    res.region_address    = addr_reg;
                    res.region_count_code = count_code;
                    res.last              = region_last;
                    addr_next = addr_reg + 64'(scdb_pkg::REGION_BYTES);
                    rem_next  = rem_reg - scdb_pkg::LEN_W'(scdb_pkg::REGION_BYTES);
                    if (region_last)
                    begin
                        pop       = 1'b1;
                        step_next = '0;
                    end
                    else
                    begin
                        step_next = step_reg + scdb_pkg::NREG_W'(1);
                    end
                end
                out_item_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        addr_reg     <= addr_next;
        rem_reg      <= rem_next;
    end

    // Mid-way through a submit the head must still be that submit, within its region count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != '0) |-> (head_valid && head_job.kind == scdb_pkg::KIND_HEADER
                              && step_reg <= head_job.nreg))
        else $error("back: region step without a matching submit at the queue head");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the SATA command descriptor builder.
// Needs scdb_pkg and the sata_command_descriptor_builder RTL; drives items, predicts results
// and checks every output item against that prediction.
`timescale 1ns / 100ps

module tb;
    import scdb_pkg::*;

    // Quiet cycles (nothing accepted on any channel) before the run is declared hung.
    localparam int QUIET_LIMIT   = 2000;
    // Length of the deliberate receiver hold-off that fills the block up.
    localparam int HOLD_CYCLES   = 80;
    // Cycles allowed after the last result for anything stray to appear.
    localparam int TAIL_CYCLES   = 20;
    localparam int PHASE_ITEMS   = 95;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

    // One line of the directed table: either an item or a slot count write.  Where
    // typed is set, the expected result is written into the row by hand.
    typedef struct {
        row_op_t    op;
        in_item_t   item;
        logic [5:0] cfg_value;
        logic       typed;
        out_item_t  result;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_item = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [5:0] cfg_data = '0;

    // Predictor state: which command slots are taken, and the slot count register.
    logic [31:0] slots_held;
    logic [5:0]  slot_count_reg;

    out_item_t pending_results[$];
    stim_row_t directed_rows[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int fail_count = 0;
    int quiet_cycles = 0;

    sata_command_descriptor_builder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Works out the result items that one accepted input item causes, and updates the
    // slot bitmap the same way the block should.  Rejections leave the bitmap alone.
    function automatic void build_descriptors(input in_item_t it, ref out_item_t res[$]);
        out_item_t   r;
        logic [63:0] regions;
        logic [63:0] offset;
        logic [63:0] remaining;
        logic [63:0] chunk;
        logic [63:0] code;
        logic [7:0]  device;
        int          usable;
        int          pick;

        res.delete();
        r = '0;
        r.last = 1'b1;
        if (it.action == ACT_RELEASE)
        begin
            slots_held[it.slot_to_free] = 1'b0;
            r.kind = KIND_RELEASED;
            r.slot = it.slot_to_free;
            res.push_back(r);
            return;
        end
        // The length check comes before the slot search, so an over-long item never
        // takes a slot even when one is free.
        regions = (64'(it.transfer_length) + REGION_BYTES - 1) / REGION_BYTES;
        if (regions > MAX_REGIONS)
        begin
            r.kind = KIND_TOO_LONG;
            res.push_back(r);
            return;
        end
        // Register values above the number of slots behave as the full set of slots.
        usable = (slot_count_reg < SLOTS_DEF) ? int'(slot_count_reg) : SLOTS_DEF;
        pick = -1;
        for (int s = usable - 1; s >= 0; s--)
            if (!slots_held[s])
                pick = s;
        if (pick < 0)
        begin
            r.kind = KIND_NO_SLOT;
            res.push_back(r);
            return;
        end
        slots_held[pick] = 1'b1;

        device = DEV_BASE | DEV_LBA_BIT | (it.lba28_mode ? {4'h0, it.lba[27:24]} : 8'h00);
        r.kind = KIND_HEADER;
        r.slot = pick[4:0];
        r.header_dword = {regions[15:0], 9'b0, it.is_write, 1'b0, FIS_DWORDS};
        r.fis_low = {device, it.lba[23:0], it.features[7:0], it.ata_command,
                     FIS_CMD_BIT, FIS_TYPE_H2D};
        r.fis_upper = {FIS_CONTROL, 8'h00, it.sector_count, it.features[15:8], it.lba[47:24]};
        r.last = (regions == 0);
        res.push_back(r);

        for (int i = 0; i < regions; i++)
        begin
            offset = 64'(i) * REGION_BYTES;
            remaining = 64'(it.transfer_length) - offset;
            chunk = (remaining > REGION_BYTES) ? 64'(REGION_BYTES) : remaining;
            // Byte count rounded up to even, minus one; a full region gives all ones.
            code = ((chunk + 1) & ~64'd1) - 1;
            r = '0;
            r.kind = KIND_REGION;
            r.slot = pick[4:0];
            r.region_address = it.buffer_address + offset;
            r.region_count_code = code[COUNT_CODE_W-1:0];
            r.last = (i == regions - 1);
            res.push_back(r);
        end
    endfunction

    function automatic in_item_t release_item(input logic [SLOT_W-1:0] s);
        in_item_t it;

        it = '0;
        it.action = ACT_RELEASE;
        it.slot_to_free = s;
        return it;
    endfunction

    function automatic out_item_t fixed_result(input logic [KIND_W-1:0] k,
                                               input logic [SLOT_W-1:0] s);
        out_item_t r;

        r = '0;
        r.kind = k;
        r.slot = s;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void add_item(input in_item_t it, input logic typed,
                                     input out_item_t res);
        stim_row_t row;

        row.op = ROW_ITEM;
        row.item = it;
        row.cfg_value = '0;
        row.typed = typed;
        row.result = res;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [5:0] v);
        stim_row_t row;

        row.op = ROW_CFG;
        row.item = '0;
        row.cfg_value = v;
        row.typed = 1'b0;
        row.result = '0;
        directed_rows.push_back(row);
    endfunction

    // Transfer lengths are spread over the interesting bands: empty, tiny, exact region
    // multiples and their neighbours, the full legal range, and lengths that are too long.
    function automatic logic [31:0] random_length();
        logic [31:0] len;
        int          k;

        case ($urandom_range(0, 9))
            0: len = 32'd0;
            1: len = $urandom_range(1, 64);
            2, 3: len = $urandom_range(1, 2 * REGION_BYTES);
            4:
            begin
                k = $urandom_range(1, MAX_REGIONS);
                len = 32'(k * REGION_BYTES) + $urandom_range(0, 2) - 1;
            end
            5: len = $urandom_range(1, MAX_REGIONS * REGION_BYTES);
            6: len = $urandom;
            7: len = $urandom_range(MAX_REGIONS * REGION_BYTES + 1, 32'hFFFF_FFFF);
            default: len = $urandom_range(1, 4 * REGION_BYTES);
        endcase
        return len;
    endfunction

    // Every field starts fully random.  Releases mostly target a slot that is taken, so
    // that slots keep coming free and submits reach the header and region path.
    function automatic in_item_t random_item();
        in_item_t it;
        int       s;

        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 99) < 40)
        begin
            it.action = ACT_RELEASE;
            if (slots_held != 0 && $urandom_range(0, 3) != 0)
            begin
                s = $urandom_range(0, 31);
                while (!slots_held[s])
                    s = $urandom_range(0, 31);
                it.slot_to_free = s[4:0];
            end
        end
        else
        begin
            it.action = ACT_SUBMIT;
            it.transfer_length = random_length();
        end
        return it;
    endfunction

    // Offers one item and holds it until the block takes it.  Entered and left at a
    // falling edge.  Gaps before the item come from the sender's idle percentage.
    task automatic feed_item(input in_item_t it, input logic typed, input out_item_t res);
        out_item_t predicted[$];

        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_item = it;
        in_valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        build_descriptors(it, predicted);
        if (typed)
            pending_results.push_back(res);
        else
            foreach (predicted[i])
                pending_results.push_back(predicted[i]);
        @(negedge clk);
    endtask

    // Stops offering items and waits for every expected result, so that the back end is
    // certainly idle before a register write.
    task automatic settle();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_slot_count(input logic [5:0] v);
        cfg_data = v;
        cfg_valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        slot_count_reg = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Receiver side.  A requested hold-off keeps the stall high for a long stretch,
    // counted here, so that the queue fills and the block stalls its own input.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("mismatch in %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Checks each result item against the oldest expectation, and watches for a hang.
    always @(posedge clk)
    begin : monitor
        out_item_t want;

        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result item with nothing expected: %p", out_item);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("kind", want.kind, out_item.kind);
                    check_field("slot", want.slot, out_item.slot);
                    check_field("header_dword", want.header_dword, out_item.header_dword);
                    check_field("fis_low", want.fis_low, out_item.fis_low);
                    check_field("fis_upper", want.fis_upper, out_item.fis_upper);
                    check_field("region_address", want.region_address,
                                out_item.region_address);
                    check_field("region_count_code", want.region_count_code,
                                out_item.region_count_code);
                    check_field("last", want.last, out_item.last);
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        in_item_t it;
        out_item_t header;
        int phase_slots[4];
        int phase_send[4];
        int phase_stall[4];

        slots_held = '0;
        slot_count_reg = SLOT_COUNT_RESET;
        phase_slots = '{32, 9, 1, 20};
        phase_send = '{0, 85, 0, 6};
        phase_stall = '{0, 0, 85, 6};

        // Directed part.  Releases straight after reset are still acknowledged.
        add_item(release_item(5'd0), 1'b1, fixed_result(KIND_RELEASED, 5'd0));
        add_item(release_item(5'd31), 1'b1, fixed_result(KIND_RELEASED, 5'd31));
        // An all-zero submit with no data: header only, slot zero, last set.
        header = fixed_result(KIND_HEADER, 5'd0);
        header.header_dword = 32'h0000_0005;
        header.fis_low = 64'hE000_0000_0000_8027;
        header.fis_upper = 64'h0800_0000_0000_0000;
        add_item('0, 1'b1, header);
        // All ones in every field with a one-byte transfer and the LBA28 device nibble.
        it = '1;
        it.action = ACT_SUBMIT;
        it.transfer_length = 32'd1;
        add_item(it, 1'b0, '0);
        // The longest legal transfer, with the buffer address wrapping past the top.
        it = '0;
        it.buffer_address = '1;
        it.transfer_length = MAX_REGIONS * REGION_BYTES;
        add_item(it, 1'b0, '0);
        // One byte too many, and the largest length of all: both too long.
        it.transfer_length = MAX_REGIONS * REGION_BYTES + 1;
        add_item(it, 1'b1, fixed_result(KIND_TOO_LONG, 5'd0));
        it.transfer_length = 32'hFFFF_FFFF;
        add_item(it, 1'b1, fixed_result(KIND_TOO_LONG, 5'd0));
        // An odd length rounds up to even.
        it = random_item();
        it.action = ACT_SUBMIT;
        it.transfer_length = 32'd3;
        add_item(it, 1'b0, '0);
        it = random_item();
        it.action = ACT_SUBMIT;
        it.lba28_mode = 1'b1;
        it.transfer_length = REGION_BYTES + 1;
        add_item(it, 1'b0, '0);
        // A slot count of zero leaves no slot free at all.
        add_cfg(6'd0);
        add_item('0, 1'b1, fixed_result(KIND_NO_SLOT, 5'd0));
        // One slot, already taken; then freed and taken again with exactly one region.
        add_cfg(6'd1);
        add_item('0, 1'b1, fixed_result(KIND_NO_SLOT, 5'd0));
        add_item(release_item(5'd0), 1'b1, fixed_result(KIND_RELEASED, 5'd0));
        it = random_item();
        it.action = ACT_SUBMIT;
        it.transfer_length = REGION_BYTES;
        add_item(it, 1'b0, '0);
        // The largest register value behaves as all slots.
        add_cfg(6'd63);
        it = random_item();
        it.action = ACT_SUBMIT;
        it.transfer_length = 32'd2;
        add_item(it, 1'b0, '0);
        add_cfg(6'd32);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == ROW_CFG)
            begin
                settle();
                write_slot_count(directed_rows[i].cfg_value);
            end
            else
            begin
                feed_item(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].result);
            end
        end

        // Random part, one phase per idling pattern.  Each phase starts from an idle
        // block: the sender waits for every expected result before the register write.
        for (int p = 0; p < 4; p++)
        begin
            settle();
            write_slot_count(6'(phase_slots[p]));
            send_idle_pct = phase_send[p];
            recv_stall_pct = phase_stall[p];
            if (p == 0)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                feed_item(random_item(), 1'b0, '0);
        end

        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
